// ===== src/kfp_pkg.sv =====
// Shared types and constants of the keyframe frame-position lookup.
package kfp_pkg;

    localparam int TIME_W     = 32;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int WHOLE_W    = 8;
    localparam int FRAC_OUT_W = 16;
    localparam int ALU_W      = TIME_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed
    {
        logic [ALU_W-1:0]   res;
        logic               zero;
    } alu_rsp_t;

endpackage

// ===== src/kfp_alu.sv =====
// Shared add/subtract unit used by the lookup sequencer for its keyframe-time arithmetic.
module kfp_alu
(
    input  kfp_pkg::alu_req_t req,
    output kfp_pkg::alu_rsp_t rsp
);

    logic [kfp_pkg::ALU_W-1:0] res;

    always_comb
    begin
        case (req.op)
            kfp_pkg::ALU_ADD: res = req.a + req.b;
            kfp_pkg::ALU_SUB: res = req.a - req.b;
            default:          res = req.a - req.b;
        endcase
    end

    assign rsp.res  = res;
    assign rsp.zero = (res == '0);

endmodule

// ===== src/kfp_table.sv =====
// Keyframe time memory: one write port and one registered read port.
module kfp_table
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [kfp_pkg::TIME_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [kfp_pkg::TIME_W-1:0]  rdata
);

    logic [kfp_pkg::TIME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/keyframe_time_to_frame_position_top.sv =====
// Keyframe frame-position lookup: sequencer, output register and configuration.
//
// Usage. The slave stream carries items: tuser = 0 stores tdata's entry_time at
// entry_index, tuser = 1 asks for the frame position of tick. Only queries give
// a transfer on the master stream: tuser flags an empty track, tdata carries the
// whole frame index and a truncated 16-bit fraction. cfg_we/cfg_wdata set the
// number of keyframes in use; write it only while the block is idle.
// Sequence. A write is stored as it is accepted and the block stays idle. A query
// first adds entry 0 to tick, runs a lower-bound search of up to ceil(log2(n+1))
// probes through the single memory read port and the shared adder, then an end
// check, the remainder and divisor subtractions and FRAC_BITS steps of restoring
// division on the same adder, and finally loads the output register; the
// subtractions and the division are skipped when the search ends at either end
// or on an exact hit. s_axis_tready is high only between items, so the next item
// is taken in the cycle after the result is loaded.
// Reset clears the keyframe count to zero and empties the output register; the
// table contents are undefined until written. A stalled master side holds its
// transfer; a following item is still accepted and waits only at its own end.
module keyframe_time_to_frame_position_top
#(
    parameter int MAX_FRAMES = 256,
    parameter int FRAC_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,       // frame_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,    // entry_index[7:0], entry_time[39:8], tick[71:40]
    input  logic        s_axis_tuser,    // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // frame_whole[7:0], frame_fraction[23:8]
    output logic        m_axis_tuser     // empty_track
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int CW = (NW > kfp_pkg::CNT_W) ? NW : kfp_pkg::CNT_W;
    localparam int WW = (NW > kfp_pkg::WHOLE_W) ? NW : kfp_pkg::WHOLE_W;
    localparam int QW = (FRAC_BITS > kfp_pkg::FRAC_OUT_W) ? FRAC_BITS : kfp_pkg::FRAC_OUT_W;
    localparam int SW = $clog2(FRAC_BITS + 1);
    localparam int TW = kfp_pkg::TIME_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SUM,
        ST_PROBE,
        ST_END,
        ST_PREV,
        ST_DEN,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t                      state_reg, state_next;
    logic [kfp_pkg::CNT_W-1:0]   frame_count_reg;
    logic [NW-1:0]               n_reg, n_next;
    logic [NW-1:0]               first_reg, first_next;
    logic [NW-1:0]               count_reg, count_next;
    logic [TW-1:0]               tick_reg, tick_next;
    logic [TW-1:0]               sum_reg, sum_next;
    logic [TW-1:0]               next_reg, next_next;
    logic [TW-1:0]               rem_reg, rem_next;
    logic [TW-1:0]               den_reg, den_next;
    logic [FRAC_BITS-1:0]        q_reg, q_next;
    logic [SW-1:0]               step_reg, step_next;
    logic [WW-1:0]               whole_reg, whole_next;
    logic                        empty_reg, empty_next;
    logic                        m_valid_reg, m_valid_next;
    logic [23:0]                 m_data_reg, m_data_next;
    logic                        m_user_reg, m_user_next;

    logic                        in_xfer;
    logic [NW-1:0]               n_calc;
    logic                        wr_ok;
    logic                        tbl_we;
    logic [IW-1:0]               raddr;
    logic [TW-1:0]               rdata;
    kfp_pkg::alu_req_t           alu_req;
    kfp_pkg::alu_rsp_t           alu_rsp;
    logic [NW-1:0]               half;
    logic [NW-1:0]               probe_first;
    logic [NW-1:0]               probe_count;
    logic                        quot_bit;
    logic [QW-1:0]               q_ext;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign n_calc        = (CW'(frame_count_reg) > CW'(MAX_FRAMES)) ?
                           NW'(MAX_FRAMES) : NW'(frame_count_reg);
    assign wr_ok         = (32'(s_axis_tdata[7:0]) < 32'(MAX_FRAMES));
    assign tbl_we        = in_xfer && (s_axis_tuser == kfp_pkg::OP_WRITE) && wr_ok;
    assign q_ext         = QW'(q_reg);

    kfp_table
    #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW)
    )
    u_table
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (IW'(s_axis_tdata[7:0])),
        .wdata (s_axis_tdata[39:8]),
        .raddr (raddr),
        .rdata (rdata)
    );

    kfp_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Probe update: the adder compares the entry read for the current middle
    // against the key, and the next middle is addressed in the same cycle.
    always_comb
    begin
        half        = count_reg >> 1;
        probe_first = first_reg;
        probe_count = half;
        if (alu_rsp.res[kfp_pkg::ALU_W-1])
        begin
            probe_first = first_reg + half + NW'(1);
            probe_count = count_reg - half - NW'(1);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        tick_next    = tick_reg;
        sum_next     = sum_reg;
        next_next    = next_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        step_next    = step_reg;
        whole_next   = whole_reg;
        empty_next   = empty_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        raddr        = '0;
        quot_bit     = 1'b0;
        alu_req.op   = kfp_pkg::ALU_SUB;
        alu_req.a    = '0;
        alu_req.b    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Entry 0 is read here so that the key can be formed next cycle.
                if (in_xfer && (s_axis_tuser == kfp_pkg::OP_QUERY))
                begin
                    n_next    = n_calc;
                    tick_next = s_axis_tdata[71:40];
                    if (n_calc == '0)
                    begin
                        empty_next = 1'b1;
                        whole_next = '0;
                        q_next     = '0;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = ST_SUM;
                    end
                end
            end

            ST_SUM:
            begin
                alu_req.op = kfp_pkg::ALU_ADD;
                alu_req.a  = kfp_pkg::ALU_W'(tick_reg);
                alu_req.b  = kfp_pkg::ALU_W'(rdata);
                sum_next   = alu_rsp.res[TW-1:0];
                first_next = '0;
                count_next = n_reg;
                raddr      = IW'(n_reg >> 1);
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                alu_req.a  = kfp_pkg::ALU_W'(rdata);
                alu_req.b  = kfp_pkg::ALU_W'(sum_reg);
                first_next = probe_first;
                count_next = probe_count;
                // With the range closed this reads the found entry itself.
                raddr      = IW'(probe_first + (probe_count >> 1));
                if (probe_count == '0)
                begin
                    state_next = ST_END;
                end
            end

            ST_END:
            begin
                alu_req.a = kfp_pkg::ALU_W'(rdata);
                alu_req.b = kfp_pkg::ALU_W'(sum_reg);
                raddr     = IW'(first_reg - NW'(1));
                q_next    = '0;
                if (first_reg == n_reg)
                begin
                    whole_next = WW'(n_reg - NW'(1));
                    state_next = ST_PUSH;
                end
                else if (first_reg == '0)
                begin
                    whole_next = '0;
                    state_next = ST_PUSH;
                end
                else if (alu_rsp.zero)
                begin
                    whole_next = WW'(first_reg);
                    state_next = ST_PUSH;
                end
                else
                begin
                    next_next  = rdata;
                    state_next = ST_PREV;
                end
            end

            ST_PREV:
            begin
                alu_req.a  = kfp_pkg::ALU_W'(sum_reg);
                alu_req.b  = kfp_pkg::ALU_W'(rdata);
                rem_next   = alu_rsp.res[TW-1:0];
                raddr      = IW'(first_reg - NW'(1));
                state_next = ST_DEN;
            end

            ST_DEN:
            begin
                alu_req.a  = kfp_pkg::ALU_W'(next_reg);
                alu_req.b  = kfp_pkg::ALU_W'(rdata);
                den_next   = alu_rsp.res[TW-1:0];
                step_next  = '0;
                q_next     = '0;
                whole_next = WW'(first_reg - NW'(1));
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring step: trial subtract of the divisor from twice the remainder.
                alu_req.a = kfp_pkg::ALU_W'({rem_reg, 1'b0});
                alu_req.b = kfp_pkg::ALU_W'(den_reg);
                if (!alu_rsp.res[kfp_pkg::ALU_W-1])
                begin
                    quot_bit = 1'b1;
                    rem_next = alu_rsp.res[TW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[TW-2:0], 1'b0};
                end
                q_next    = {q_reg[FRAC_BITS-2:0], quot_bit};
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(FRAC_BITS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {q_ext[kfp_pkg::FRAC_OUT_W-1:0],
                                    whole_reg[kfp_pkg::WHOLE_W-1:0]};
                    m_user_next  = empty_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= '0;
            n_reg           <= '0;
            first_reg       <= '0;
            count_reg       <= '0;
            tick_reg        <= '0;
            sum_reg         <= '0;
            next_reg        <= '0;
            rem_reg         <= '0;
            den_reg         <= '0;
            q_reg           <= '0;
            step_reg        <= '0;
            whole_reg       <= '0;
            empty_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_user_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                frame_count_reg <= cfg_wdata;
            end
            n_reg           <= n_next;
            first_reg       <= first_next;
            count_reg       <= count_next;
            tick_reg        <= tick_next;
            sum_reg         <= sum_next;
            next_reg        <= next_next;
            rem_reg         <= rem_next;
            den_reg         <= den_next;
            q_reg           <= q_next;
            step_reg        <= step_next;
            whole_reg       <= whole_next;
            empty_reg       <= empty_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
            m_user_reg      <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_probe_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> count_reg != '0)
        else $error("search probe with an empty range");

    a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |->
            ((NW+1)'(first_reg) + (NW+1)'(count_reg)) <= (NW+1)'(n_reg))
        else $error("search range runs past the entries in use");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("division remainder not below divisor");

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_PUSH))
        else $error("result transfer raised outside the final step");
`endif

endmodule
